[hw/rtl/mfd_pkg.sv]
// Shared types and constants for the MSP frame deframer.
// No dependencies; used by every module of the deframer.
`timescale 1ns / 1ps

package mfd_pkg;

    localparam logic [7:0] HDR_START = 8'h24;   // '$'
    localparam logic [7:0] HDR_PROTO = 8'h4D;   // 'M'
    localparam logic [7:0] HDR_DIR   = 8'h3E;   // '>'

    localparam int unsigned BODY_XOR_LEN = 12;
    localparam int unsigned BODY_IDX_W   = 4;

    // Frame phase: three header phases, twelve body phases, checksum phase.
    typedef enum logic [3:0] {
        PH_HUNT_START = 4'd0,
        PH_HUNT_PROTO = 4'd1,
        PH_HUNT_DIR   = 4'd2,
        PH_BODY0      = 4'd3,
        PH_BODY1      = 4'd4,
        PH_BODY2      = 4'd5,
        PH_BODY3      = 4'd6,
        PH_BODY4      = 4'd7,
        PH_BODY5      = 4'd8,
        PH_BODY6      = 4'd9,
        PH_BODY7      = 4'd10,
        PH_BODY8      = 4'd11,
        PH_BODY9      = 4'd12,
        PH_BODY10     = 4'd13,
        PH_BODY11     = 4'd14,
        PH_CHECKSUM   = 4'd15
    } t_phase;

    typedef struct packed {
        logic [7:0]         length_field;
        logic [7:0]         command_code;
        logic signed [15:0] word_zero;
        logic signed [15:0] word_one;
        logic signed [15:0] word_two;
        logic signed [15:0] word_three;
        logic signed [15:0] word_four;
        logic               checksum_ok;
    } t_result;

endpackage

[hw/rtl/mfd_frame_fsm.sv]
// Header hunt, body capture and running XOR for the MSP frame deframer.
// Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_frame_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_last,
    output mfd_pkg::t_result o_result
);

    mfd_pkg::t_phase r_phase;
    mfd_pkg::t_phase n_phase;
    logic [7:0]      r_xor;
    logic [7:0]      n_xor;
    logic [7:0]      r_body [mfd_pkg::BODY_XOR_LEN];
    logic [mfd_pkg::BODY_IDX_W-1:0] body_idx;
    logic            is_body;

    assign body_idx = mfd_pkg::BODY_IDX_W'(r_phase - mfd_pkg::PH_BODY0);
    assign is_body  = (r_phase >= mfd_pkg::PH_BODY0) && (r_phase != mfd_pkg::PH_CHECKSUM);
    assign o_last   = (r_phase == mfd_pkg::PH_CHECKSUM);

    always_comb begin
        n_phase = r_phase;
        n_xor   = r_xor;
        unique case (r_phase)
            mfd_pkg::PH_HUNT_START: begin
                n_phase = (i_byte == mfd_pkg::HDR_START) ? mfd_pkg::PH_HUNT_PROTO
                                                          : mfd_pkg::PH_HUNT_START;
            end
            mfd_pkg::PH_HUNT_PROTO: begin
                if (i_byte == mfd_pkg::HDR_PROTO) begin
                    n_phase = mfd_pkg::PH_HUNT_DIR;
                end else begin
                    n_phase = (i_byte == mfd_pkg::HDR_START) ? mfd_pkg::PH_HUNT_PROTO
                                                              : mfd_pkg::PH_HUNT_START;
                end
            end
            mfd_pkg::PH_HUNT_DIR: begin
                if (i_byte == mfd_pkg::HDR_DIR) begin
                    n_phase = mfd_pkg::PH_BODY0;
                    n_xor   = 8'd0;
                end else begin
                    n_phase = (i_byte == mfd_pkg::HDR_START) ? mfd_pkg::PH_HUNT_PROTO
                                                              : mfd_pkg::PH_HUNT_START;
                end
            end
            mfd_pkg::PH_CHECKSUM: begin
                n_phase = mfd_pkg::PH_HUNT_START;
                n_xor   = 8'd0;
            end
            default: begin
                // body bytes: advance one phase, fold byte into the XOR
                n_phase = mfd_pkg::t_phase'(r_phase + 4'd1);
                n_xor   = r_xor ^ i_byte;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mfd_pkg::PH_HUNT_START;
            r_xor   <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && is_body) begin
            r_body[body_idx] <= i_byte;
        end
    end

    always_comb begin
        o_result.length_field = r_body[0];
        o_result.command_code = r_body[1];
        o_result.word_zero    = {r_body[3],  r_body[2]};
        o_result.word_one     = {r_body[5],  r_body[4]};
        o_result.word_two     = {r_body[7],  r_body[6]};
        o_result.word_three   = {r_body[9],  r_body[8]};
        o_result.word_four    = {r_body[11], r_body[10]};
        o_result.checksum_ok  = (r_xor == i_byte);
    end

endmodule

[hw/rtl/mfd_out_reg.sv]
// Result register of the MSP frame deframer: holds one frame until taken.
// Depends on mfd_pkg.
`timescale 1ns / 1ps

module mfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mfd_pkg::t_result i_result,
    input  logic             i_out_ready,
    output logic             o_free,
    output logic             o_out_valid,
    output mfd_pkg::t_result o_result
);

    logic             r_valid;
    mfd_pkg::t_result r_result;

    // slot is free if empty or being drained this cycle
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

[hw/rtl/msp_frame_deframer_core.sv]
// MSP frame deframer, top level: input register, frame logic, result register.
// Depends on mfd_pkg, mfd_frame_fsm and mfd_out_reg.
//
// Usage:
//   Feed received serial bytes on i_rx_byte with i_in_valid / o_in_ready.
//   The block hunts '$','M','>' and then collects a 13-byte body (length,
//   command, 10 payload bytes, checksum). On the checksum byte it presents
//   one result on the output channel (o_out_valid / i_out_ready): length,
//   command, five little-endian signed words and checksum_ok. The payload
//   is delivered even when the checksum fails.
// Timing:
//   One byte per cycle while no checksum byte waits for a full result register.
//   The checksum byte passes the input register, then the result is registered.
// Reset:
//   Synchronous, active low; clears both registers' valid flags, the frame
//   phase (back to hunting '$') and the running XOR.
// Stall:
//   Bytes that make no result keep flowing while a result waits. Only a
//   checksum byte waits in the input register for the result register to
//   free up, and then o_in_ready drops.
`timescale 1ns / 1ps

module msp_frame_deframer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_length_field,
    output logic [7:0]         o_command_code,
    output logic signed [15:0] o_word_zero,
    output logic signed [15:0] o_word_one,
    output logic signed [15:0] o_word_two,
    output logic signed [15:0] o_word_three,
    output logic signed [15:0] o_word_four,
    output logic               o_checksum_ok
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             step;
    logic             last;
    logic             out_free;
    mfd_pkg::t_result fsm_result;
    mfd_pkg::t_result out_result;

    // a held byte is consumed unless it closes a frame and the slot is full
    assign step       = r_in_valid && (!last || out_free);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mfd_frame_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_last   (last),
        .o_result (fsm_result)
    );

    mfd_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && last),
        .i_result    (fsm_result),
        .i_out_ready (i_out_ready),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_length_field = out_result.length_field;
    assign o_command_code = out_result.command_code;
    assign o_word_zero    = out_result.word_zero;
    assign o_word_one     = out_result.word_one;
    assign o_word_two     = out_result.word_two;
    assign o_word_three   = out_result.word_three;
    assign o_word_four    = out_result.word_four;
    assign o_checksum_ok  = out_result.checksum_ok;

endmodule
